/* rtl/melody_tone_duration_generator_core_macros.svh */
// Assertion macros shared by the tone generator checker
`ifndef MELODY_TONE_DURATION_GENERATOR_CORE_MACROS_SVH
`define MELODY_TONE_DURATION_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MTDG_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mtdg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define MTDG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtdg: next-cycle check failed");

`endif

/* rtl/mtdg_pkg.sv */
// Package: types, constants and codes for the tone and note length generator
package mtdg_pkg;

   // field widths
   localparam int unsigned CLK_W   = 25;
   localparam int unsigned TEMPO_W = 10;
   localparam int unsigned FREQ_W  = 14;
   localparam int unsigned NDIV_W  = 8;
   localparam int unsigned HP_W    = 16;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned TQ_W    = 18;

   // duration prescaler
   localparam int unsigned PRESCALE = 1024;
   localparam int unsigned PRESC_W  = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;

   // serial divider geometry
   localparam int unsigned DVD_W = CLK_W;
   localparam int unsigned DVS_W = FREQ_W;
   localparam int unsigned CNT_W = $clog2(DVD_W);

   // constants
   localparam logic [CLK_W-1:0]   CLOCK_HZ_RST = 25'd16000000;
   localparam logic [TEMPO_W-1:0] TEMPO_RST    = 10'd120;
   localparam logic [TQ_W-1:0]    LEN_BASE     = 18'd240000;
   localparam logic [LEN_W-1:0]   LEN_MAX      = 16'd32767;
   localparam logic [HP_W-1:0]    HP_MAX       = 16'hFFFF;

   // register indexes
   localparam int unsigned CSR_W = 1;
   localparam logic [CSR_W-1:0] CSR_CLOCK_HZ  = 1'b0;
   localparam logic [CSR_W-1:0] CSR_TEMPO_BPM = 1'b1;

   // function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [FREQ_W-1:0]        note_freq;
      logic signed [NDIV_W-1:0] note_div;
   } req_word_type;

   typedef struct packed {
      logic buzzer_level;
      logic note_done;
      logic bad_note;
   } rsp_word_type;

   // divider control
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   // note setup request into the sequencer
   typedef struct packed {
      logic               valid;
      logic [FREQ_W-1:0]  freq;
      logic [NDIV_W-1:0]  mag;
      logic               dotted;
      logic [CLK_W-1:0]   clock_hz;
      logic [TEMPO_W-1:0] tempo;
   } seq_start_type;

   // limit update from sequencer to timer
   typedef struct packed {
      logic             we;
      logic             hp_we;
      logic [HP_W-1:0]  half_period;
      logic [LEN_W-1:0] length_limit;
   } lim_upd_type;

   // events into the timer
   typedef struct packed {
      logic tick;
      logic load;
      logic load_ok;
      logic tone_req;
   } tmr_cmd_type;

   typedef struct packed {
      logic level;
      logic done;
   } tmr_stat_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_HP_GO,
      SEQ_HP_WAIT,
      SEQ_TEMPO_GO,
      SEQ_TEMPO_WAIT,
      SEQ_MAG_GO,
      SEQ_MAG_WAIT,
      SEQ_FINISH
   } seq_state_type;

endpackage

/* rtl/melody_tone_duration_generator_core.sv */
// Top level: handshake, configuration registers, output register and submodules
// Tick words: one per cycle unless busy or stalled by the receiver; result in the
//   cycle after acceptance. Load words: result in the cycle after acceptance; after a
//   load with a nonzero divisor the next word is held off while two divisions (rest) or
//   three (tone) run on the single shared one-bit-per-cycle divider.
// Reset: synchronous, active high; registers return to 16000000 Hz and 120 bpm,
//   level high, no note active.
module melody_tone_duration_generator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mtdg_pkg::req_word_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mtdg_pkg::rsp_word_type        rsp_data,
   input  logic                          csr_we,
   input  logic [mtdg_pkg::CSR_W-1:0]    csr_index,
   input  logic [mtdg_pkg::CLK_W-1:0]    csr_wdata
);

   logic [mtdg_pkg::CLK_W-1:0]   clock_hz_ff, clock_hz_in;
   logic [mtdg_pkg::TEMPO_W-1:0] tempo_bpm_ff, tempo_bpm_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   mtdg_pkg::rsp_word_type       rsp_data_ff, rsp_data_in;

   logic                         busy;
   logic                         accept;
   logic                         div_zero;
   logic [mtdg_pkg::NDIV_W-1:0]  div_bits;
   mtdg_pkg::seq_start_type      seq_start;
   mtdg_pkg::div_req_type        div_req;
   mtdg_pkg::div_rsp_type        div_rsp;
   mtdg_pkg::lim_upd_type        upd;
   mtdg_pkg::tmr_cmd_type        tmr_cmd;
   mtdg_pkg::tmr_stat_type       tmr_stat;

   // configuration writes
   always_comb begin
      clock_hz_in  = clock_hz_ff;
      tempo_bpm_in = tempo_bpm_ff;
      if (csr_we) begin
         case (csr_index)
            mtdg_pkg::CSR_CLOCK_HZ:  clock_hz_in  = csr_wdata;
            mtdg_pkg::CSR_TEMPO_BPM: tempo_bpm_in = csr_wdata[mtdg_pkg::TEMPO_W-1:0];
            default:                 clock_hz_in  = clock_hz_ff;
         endcase
      end
   end

   // input decode
   always_comb begin
      req_ready = !busy && (!rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
      div_bits  = req_data.note_div;
      div_zero  = div_bits == '0;

      tmr_cmd.tick     = accept && (req_data.func == mtdg_pkg::FUNC_TICK);
      tmr_cmd.load     = accept && (req_data.func == mtdg_pkg::FUNC_LOAD);
      tmr_cmd.load_ok  = !div_zero;
      tmr_cmd.tone_req = req_data.note_freq != '0;

      seq_start.valid    = tmr_cmd.load && !div_zero;
      seq_start.freq     = req_data.note_freq;
      seq_start.dotted   = div_bits[mtdg_pkg::NDIV_W-1];
      seq_start.mag      = div_bits[mtdg_pkg::NDIV_W-1] ? (~div_bits + 1'b1) : div_bits;
      seq_start.clock_hz = clock_hz_ff;
      seq_start.tempo    = tempo_bpm_ff;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.buzzer_level = tmr_stat.level;
         rsp_data_in.note_done    = tmr_stat.done;
         rsp_data_in.bad_note     = tmr_cmd.load && div_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= mtdg_pkg::CLOCK_HZ_RST;
         tempo_bpm_ff <= mtdg_pkg::TEMPO_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         clock_hz_ff  <= clock_hz_in;
         tempo_bpm_ff <= tempo_bpm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   mtdg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   mtdg_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .upd     (upd),
      .busy    (busy)
   );

   mtdg_timer u_timer (
      .clock (clock),
      .reset (reset),
      .cmd   (tmr_cmd),
      .upd   (upd),
      .stat  (tmr_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/mtdg_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle
module mtdg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mtdg_pkg::div_req_type req,
   output mtdg_pkg::div_rsp_type rsp
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [mtdg_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [mtdg_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [mtdg_pkg::DVD_W-1:0]    quo_ff, quo_in;
   logic [mtdg_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [mtdg_pkg::DVS_W:0]      trial;
   logic [mtdg_pkg::DVS_W:0]      diff;
   logic                          ge;

   // one restoring step: shift in the next dividend bit, try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[mtdg_pkg::DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
      end else if (run_ff) begin
         rem_in = ge ? diff[mtdg_pkg::DVS_W-1:0] : trial[mtdg_pkg::DVS_W-1:0];
         quo_in = {quo_ff[mtdg_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mtdg_pkg::CNT_W'(mtdg_pkg::DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/mtdg_seq.sv */
// Note setup sequencer: runs half period and note length divisions on the shared divider
module mtdg_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  mtdg_pkg::seq_start_type start,
   output mtdg_pkg::div_req_type   div_req,
   input  mtdg_pkg::div_rsp_type   div_rsp,
   output mtdg_pkg::lim_upd_type   upd,
   output logic                    busy
);

   mtdg_pkg::seq_state_type state_ff, state_in;

   logic [mtdg_pkg::FREQ_W-1:0]  freq_ff, freq_in;
   logic [mtdg_pkg::NDIV_W-1:0]  mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [mtdg_pkg::CLK_W-1:0]   clk_ff, clk_in;
   logic [mtdg_pkg::TEMPO_W-1:0] tempo_ff, tempo_in;
   logic [mtdg_pkg::TQ_W-1:0]    tq_ff, tq_in;
   logic [mtdg_pkg::HP_W-1:0]    hp_ff, hp_in;
   logic [mtdg_pkg::LEN_W-1:0]   len_ff, len_in;

   logic [mtdg_pkg::DVD_W-2:0]   q_half;
   logic [mtdg_pkg::HP_W-1:0]    hp_sat;
   logic [mtdg_pkg::LEN_W-1:0]   len_sat;
   logic [mtdg_pkg::LEN_W:0]     dot_sum;
   logic [mtdg_pkg::LEN_W-1:0]   dot_len;
   logic [mtdg_pkg::LEN_W-1:0]   scaled;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtdg_pkg::SEQ_IDLE: begin
            if (start.valid) begin
               state_in = (start.freq != '0) ? mtdg_pkg::SEQ_HP_GO : mtdg_pkg::SEQ_TEMPO_GO;
            end
         end
         mtdg_pkg::SEQ_HP_GO:      state_in = mtdg_pkg::SEQ_HP_WAIT;
         mtdg_pkg::SEQ_HP_WAIT: begin
            if (div_rsp.done) state_in = mtdg_pkg::SEQ_TEMPO_GO;
         end
         mtdg_pkg::SEQ_TEMPO_GO:   state_in = mtdg_pkg::SEQ_TEMPO_WAIT;
         mtdg_pkg::SEQ_TEMPO_WAIT: begin
            if (div_rsp.done) state_in = mtdg_pkg::SEQ_MAG_GO;
         end
         mtdg_pkg::SEQ_MAG_GO:     state_in = mtdg_pkg::SEQ_MAG_WAIT;
         mtdg_pkg::SEQ_MAG_WAIT: begin
            if (div_rsp.done) state_in = mtdg_pkg::SEQ_FINISH;
         end
         mtdg_pkg::SEQ_FINISH:     state_in = mtdg_pkg::SEQ_IDLE;
         default:                  state_in = mtdg_pkg::SEQ_IDLE;
      endcase
   end

   // divider requests and limit update
   always_comb begin
      div_req   = '0;
      upd.we    = 1'b0;
      upd.hp_we = 1'b0;
      case (state_ff)
         mtdg_pkg::SEQ_HP_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = clk_ff;
            div_req.divisor  = freq_ff;
         end
         mtdg_pkg::SEQ_TEMPO_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = mtdg_pkg::DVD_W'(mtdg_pkg::LEN_BASE);
            div_req.divisor  = mtdg_pkg::DVS_W'(tempo_ff);
         end
         mtdg_pkg::SEQ_MAG_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = mtdg_pkg::DVD_W'(tq_ff);
            div_req.divisor  = mtdg_pkg::DVS_W'(mag_ff);
         end
         mtdg_pkg::SEQ_FINISH: begin
            upd.we    = 1'b1;
            upd.hp_we = freq_ff != '0;
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   // saturation and length scaling
   always_comb begin
      q_half  = div_rsp.quotient[mtdg_pkg::DVD_W-1:1];
      hp_sat  = (q_half[mtdg_pkg::DVD_W-2:mtdg_pkg::HP_W] != '0) ? mtdg_pkg::HP_MAX
                                                               : q_half[mtdg_pkg::HP_W-1:0];
      // length doubled, clipped to 15 bits
      len_sat = (div_rsp.quotient[mtdg_pkg::DVD_W-1:mtdg_pkg::LEN_W-2] != '0)
                ? mtdg_pkg::LEN_MAX
                : {div_rsp.quotient[mtdg_pkg::LEN_W-2:0], 1'b0};
      // dotted: times 3/2, clipped again
      dot_sum = {1'b0, len_ff} + {2'b00, len_ff[mtdg_pkg::LEN_W-1:1]};
      if (!neg_ff) begin
         dot_len = len_ff;
      end else if (dot_sum > {1'b0, mtdg_pkg::LEN_MAX}) begin
         dot_len = mtdg_pkg::LEN_MAX;
      end else begin
         dot_len = dot_sum[mtdg_pkg::LEN_W-1:0];
      end
      scaled = dot_len - (dot_len >> 5) + (dot_len >> 7);
   end

   // data register next values
   always_comb begin
      freq_in  = freq_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      clk_in   = clk_ff;
      tempo_in = tempo_ff;
      tq_in    = tq_ff;
      hp_in    = hp_ff;
      len_in   = len_ff;
      if (state_ff == mtdg_pkg::SEQ_IDLE && start.valid) begin
         freq_in  = start.freq;
         mag_in   = start.mag;
         neg_in   = start.dotted;
         clk_in   = start.clock_hz;
         tempo_in = (start.tempo == '0) ? mtdg_pkg::TEMPO_W'(1) : start.tempo;
      end
      if (state_ff == mtdg_pkg::SEQ_HP_WAIT && div_rsp.done) begin
         hp_in = hp_sat;
      end
      if (state_ff == mtdg_pkg::SEQ_TEMPO_WAIT && div_rsp.done) begin
         tq_in = div_rsp.quotient[mtdg_pkg::TQ_W-1:0];
      end
      if (state_ff == mtdg_pkg::SEQ_MAG_WAIT && div_rsp.done) begin
         len_in = len_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtdg_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff  <= freq_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      clk_ff   <= clk_in;
      tempo_ff <= tempo_in;
      tq_ff    <= tq_in;
      hp_ff    <= hp_in;
      len_ff   <= len_in;
   end

   assign upd.half_period  = hp_ff;
   assign upd.length_limit = scaled;
   assign busy             = state_ff != mtdg_pkg::SEQ_IDLE;

endmodule

/* rtl/mtdg_timer.sv */
// Tone and note length timer: square wave counter, prescaler and length counter
module mtdg_timer (
   input  logic                  clock,
   input  logic                  reset,
   input  mtdg_pkg::tmr_cmd_type  cmd,
   input  mtdg_pkg::lim_upd_type  upd,
   output mtdg_pkg::tmr_stat_type stat
);

   logic [mtdg_pkg::HP_W-1:0]    hp_ff, hp_in;
   logic [mtdg_pkg::HP_W-1:0]    tone_cnt_ff, tone_cnt_in;
   logic                         level_ff, level_in;
   logic                         tone_on_ff, tone_on_in;
   logic [mtdg_pkg::PRESC_W-1:0] presc_ff, presc_in;
   logic [mtdg_pkg::LEN_W-1:0]   lim_ff, lim_in;
   logic [mtdg_pkg::LEN_W-1:0]   len_cnt_ff, len_cnt_in;
   logic                         active_ff, active_in;
   logic                         done;
   logic [mtdg_pkg::HP_W-1:0]    hp_eff;
   logic [mtdg_pkg::HP_W:0]      tone_nxt;
   logic [mtdg_pkg::LEN_W-1:0]   len_nxt;

   always_comb begin
      hp_eff   = (hp_ff == '0) ? mtdg_pkg::HP_W'(1) : hp_ff;
      tone_nxt = {1'b0, tone_cnt_ff} + 1'b1;
      len_nxt  = len_cnt_ff + 1'b1;
   end

   // state update on loads, ticks and limit writes
   always_comb begin
      hp_in       = hp_ff;
      tone_cnt_in = tone_cnt_ff;
      level_in    = level_ff;
      tone_on_in  = tone_on_ff;
      presc_in    = presc_ff;
      lim_in      = lim_ff;
      len_cnt_in  = len_cnt_ff;
      active_in   = active_ff;
      done        = 1'b0;
      if (upd.we) begin
         lim_in = upd.length_limit;
         if (upd.hp_we) hp_in = upd.half_period;
      end
      if (cmd.load) begin
         tone_cnt_in = '0;
         presc_in    = '0;
         len_cnt_in  = '0;
         active_in   = cmd.load_ok;
         tone_on_in  = cmd.load_ok && cmd.tone_req;
      end else if (cmd.tick && active_ff) begin
         // tone half period
         if (tone_on_ff) begin
            if (tone_nxt >= {1'b0, hp_eff}) begin
               tone_cnt_in = '0;
               level_in    = !level_ff;
            end else begin
               tone_cnt_in = tone_nxt[mtdg_pkg::HP_W-1:0];
            end
         end
         // prescaled note length
         if (presc_ff >= mtdg_pkg::PRESC_W'(mtdg_pkg::PRESCALE - 1)) begin
            presc_in   = '0;
            len_cnt_in = len_nxt;
            if (len_nxt >= lim_ff) begin
               done       = 1'b1;
               active_in  = 1'b0;
               tone_on_in = 1'b0;
            end
         end else begin
            presc_in = presc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff       <= '0;
         tone_cnt_ff <= '0;
         level_ff    <= 1'b1;
         tone_on_ff  <= 1'b0;
         presc_ff    <= '0;
         lim_ff      <= '0;
         len_cnt_ff  <= '0;
         active_ff   <= 1'b0;
      end else begin
         hp_ff       <= hp_in;
         tone_cnt_ff <= tone_cnt_in;
         level_ff    <= level_in;
         tone_on_ff  <= tone_on_in;
         presc_ff    <= presc_in;
         lim_ff      <= lim_in;
         len_cnt_ff  <= len_cnt_in;
         active_ff   <= active_in;
      end
   end

   assign stat.level = level_in;
   assign stat.done  = done;

endmodule

/* rtl/mtdg_checker.sv */
// Port-level checker for the tone generator, bound to the top level
`include "melody_tone_duration_generator_core_macros.svh"

module mtdg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input mtdg_pkg::req_word_type     req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input mtdg_pkg::rsp_word_type     rsp_data,
   input logic                       csr_we,
   input logic [mtdg_pkg::CSR_W-1:0] csr_index,
   input logic [mtdg_pkg::CLK_W-1:0] csr_wdata
);

   logic acc_load;
   logic acc_tick;

   assign acc_load = req_valid && req_ready && (req_data.func == mtdg_pkg::FUNC_LOAD);
   assign acc_tick = req_valid && req_ready && (req_data.func == mtdg_pkg::FUNC_TICK);

   // a stalled result word stays
   `MTDG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // output register empty right after reset
   `MTDG_ASSERT_SAME(a_rsp_reset, $past(reset), !rsp_valid)
   // zero divisor load reports bad_note next cycle
   `MTDG_ASSERT_NEXT(a_bad_load, acc_load && (req_data.note_div == '0), rsp_valid && rsp_data.bad_note)
   // a tick never reports bad_note
   `MTDG_ASSERT_NEXT(a_tick_ok, acc_tick, rsp_valid && !rsp_data.bad_note)
   // a valid load holds off the next word while limits are computed
   `MTDG_ASSERT_NEXT(a_load_busy, acc_load && (req_data.note_div != '0), !req_ready)

endmodule

bind melody_tone_duration_generator_core mtdg_checker u_mtdg_checker (.*);

/* test/melody_tone_duration_generator_core_tb.sv */
// Testbench for the tone and note length generator: directed and random words vs. a predictor
module melody_tone_duration_generator_core_tb;

   // clock, reset and ports
   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   mtdg_pkg::req_word_type         req_data;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   mtdg_pkg::rsp_word_type         rsp_data;
   logic                           csr_we;
   logic [mtdg_pkg::CSR_W-1:0]     csr_index;
   logic [mtdg_pkg::CLK_W-1:0]     csr_wdata;

   // idle rates in percent of cycles
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned mismatch_count = 0;

   // predicted results in acceptance order
   mtdg_pkg::rsp_word_type rsp_due_q[$];

   // predictor copy of registers and timer state
   logic [mtdg_pkg::CLK_W-1:0]   cfg_clock;
   logic [mtdg_pkg::TEMPO_W-1:0] cfg_tempo;
   logic [mtdg_pkg::HP_W-1:0]    tone_half;
   logic [mtdg_pkg::HP_W-1:0]    tone_cnt;
   logic                         buzz;
   logic                         tone_run;
   logic [mtdg_pkg::PRESC_W-1:0] presc_cnt;
   logic [mtdg_pkg::LEN_W-1:0]   len_limit;
   logic [mtdg_pkg::LEN_W-1:0]   len_cnt;
   logic                         note_run;

   melody_tone_duration_generator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // predictor: advances the timer model by one word and returns its result
   function automatic mtdg_pkg::rsp_word_type tone_step(input mtdg_pkg::req_word_type w);
      mtdg_pkg::rsp_word_type r;
      logic [mtdg_pkg::NDIV_W-1:0] dv;
      int unsigned mag, tempo, span, hp, nxt;
      r  = '0;
      dv = w.note_div;
      if (w.func == mtdg_pkg::FUNC_LOAD) begin
         tone_cnt  = '0;
         presc_cnt = '0;
         len_cnt   = '0;
         if (dv == '0) begin
            r.bad_note = 1'b1;
            note_run   = 1'b0;
            tone_run   = 1'b0;
         end else begin
            mag = dv[mtdg_pkg::NDIV_W-1] ? 256 - int'(dv) : int'(dv);
            if (w.note_freq != '0) begin
               hp        = cfg_clock / w.note_freq / 2;
               tone_half = (hp > mtdg_pkg::HP_MAX) ? mtdg_pkg::HP_MAX : hp[mtdg_pkg::HP_W-1:0];
               tone_run  = 1'b1;
            end else begin
               tone_run = 1'b0;
            end
            // note length, dotted stretch, then the 1 - 1/32 + 1/128 trim
            tempo = (cfg_tempo == '0) ? 1 : cfg_tempo;
            span  = (mtdg_pkg::LEN_BASE / tempo) / mag * 2;
            if (span > mtdg_pkg::LEN_MAX) span = mtdg_pkg::LEN_MAX;
            if (dv[mtdg_pkg::NDIV_W-1]) begin
               span = span * 3 / 2;
               if (span > mtdg_pkg::LEN_MAX) span = mtdg_pkg::LEN_MAX;
            end
            span      = span - span / 32 + span / 128;
            len_limit = span[mtdg_pkg::LEN_W-1:0];
            note_run  = 1'b1;
         end
      end else if (note_run) begin
         if (tone_run) begin
            hp  = (tone_half == '0) ? 1 : tone_half;
            nxt = tone_cnt + 1;
            if (nxt >= hp) begin
               tone_cnt = '0;
               buzz     = ~buzz;
            end else begin
               tone_cnt = nxt[mtdg_pkg::HP_W-1:0];
            end
         end
         if (presc_cnt >= mtdg_pkg::PRESCALE - 1) begin
            presc_cnt = '0;
            len_cnt   = len_cnt + 1'b1;
            if (len_cnt >= len_limit) begin
               r.note_done = 1'b1;
               note_run    = 1'b0;
               tone_run    = 1'b0;
            end
         end else begin
            presc_cnt = presc_cnt + 1'b1;
         end
      end
      r.buzzer_level = buzz;
      return r;
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : rsp_check
      mtdg_pkg::rsp_word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due_q.size() == 0) begin
            $display("%0t unexpected result word: expected none, actual %b", $time, rsp_data);
            mismatch_count++;
         end else begin
            due = rsp_due_q.pop_front();
            if (rsp_data.buzzer_level !== due.buzzer_level) begin
               $display("%0t buzzer_level: expected %b, actual %b",
                        $time, due.buzzer_level, rsp_data.buzzer_level);
               mismatch_count++;
            end
            if (rsp_data.note_done !== due.note_done) begin
               $display("%0t note_done: expected %b, actual %b",
                        $time, due.note_done, rsp_data.note_done);
               mismatch_count++;
            end
            if (rsp_data.bad_note !== due.bad_note) begin
               $display("%0t bad_note: expected %b, actual %b",
                        $time, due.bad_note, rsp_data.bad_note);
               mismatch_count++;
            end
         end
      end
   end

   // send one word; valid stays up until it is taken
   task automatic send_word(input logic fn, input logic [mtdg_pkg::FREQ_W-1:0] freq,
                            input logic [mtdg_pkg::NDIV_W-1:0] dv);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_data.func      = fn;
      req_data.note_freq = freq;
      req_data.note_div  = dv;
      do @(posedge clock); while (!req_ready);
      rsp_due_q.push_back(tone_step(req_data));
   endtask

   // stop sending, wait for every result, then let the divider finish
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (rsp_due_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // register write; only called while the block is quiet
   task automatic write_csr(input logic [mtdg_pkg::CSR_W-1:0] idx,
                            input logic [mtdg_pkg::CLK_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == mtdg_pkg::CSR_CLOCK_HZ) cfg_clock = value;
      else cfg_tempo = value[mtdg_pkg::TEMPO_W-1:0];
   endtask

   // field extremes, bad divisor, rests, dotted notes and idle ticks at reset settings
   task automatic test_directed_loads();
      send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      send_word(mtdg_pkg::FUNC_TICK, '1, '1);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd16383, 8'sd1);
      repeat (3) send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd0, 8'sd0);
      send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd440, -8'sd4);
      send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd1, 8'sd127);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd16383, -8'sd128);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd8191, 8'sd64);
      repeat (2) send_word(mtdg_pkg::FUNC_TICK, '1, '1);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd0, -8'sd64);
      send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd9000, -8'sd1);
      send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      settle();
   endtask

   // register corners: zero and tiny clock, saturated half period, zero and max tempo
   task automatic test_config_corners();
      write_csr(mtdg_pkg::CSR_CLOCK_HZ, '0);
      write_csr(mtdg_pkg::CSR_TEMPO_BPM, '0);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd1, 8'sd1);
      repeat (4) send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      settle();
      write_csr(mtdg_pkg::CSR_CLOCK_HZ, 25'd5);
      write_csr(mtdg_pkg::CSR_TEMPO_BPM, '1);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd16383, -8'sd1);
      repeat (3) send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd2, -8'sd128);
      repeat (3) send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      settle();
      write_csr(mtdg_pkg::CSR_CLOCK_HZ, '1);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd1, 8'sd2);
      repeat (2) send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      settle();
   endtask

   // shortest tone runs to the end (two prescaler wraps), then idle ticks
   task automatic test_note_completion();
      settle();
      write_csr(mtdg_pkg::CSR_CLOCK_HZ, 25'd1000000);
      write_csr(mtdg_pkg::CSR_TEMPO_BPM, '1);
      send_word(mtdg_pkg::FUNC_LOAD, 14'd16383, 8'sd127);
      while (note_run) begin
         send_word(mtdg_pkg::FUNC_TICK, mtdg_pkg::FREQ_W'($urandom),
                   mtdg_pkg::NDIV_W'($urandom));
      end
      repeat (3) send_word(mtdg_pkg::FUNC_TICK, '0, '0);
      settle();
   endtask

   // mostly load-then-tick bursts with random content, some stray words
   task automatic test_random_melody(input int unsigned n_words,
                                     input logic [mtdg_pkg::CLK_W-1:0] clk_hz,
                                     input logic [mtdg_pkg::TEMPO_W-1:0] bpm);
      int unsigned sent, burst, sel;
      logic [mtdg_pkg::FREQ_W-1:0] freq;
      logic [mtdg_pkg::NDIV_W-1:0] dv;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      settle();
      write_csr(mtdg_pkg::CSR_CLOCK_HZ, clk_hz);
      write_csr(mtdg_pkg::CSR_TEMPO_BPM, bpm);
      while (sent < n_words) begin
         // sender holds off once until the pipe is empty
         if (!paused && sent >= n_words / 2) begin
            settle();
            paused = 1'b1;
         end
         sel = $urandom_range(9);
         if (sel == 0) freq = '0;
         else if (sel < 5) freq = mtdg_pkg::FREQ_W'($urandom_range(8192, 16383));
         else freq = mtdg_pkg::FREQ_W'($urandom_range(0, 16383));
         dv = ($urandom_range(19) == 0) ? '0 : mtdg_pkg::NDIV_W'($urandom_range(0, 255));
         if ($urandom_range(99) < 80) begin
            send_word(mtdg_pkg::FUNC_LOAD, freq, dv);
            burst = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
            repeat (burst) begin
               send_word(mtdg_pkg::FUNC_TICK, mtdg_pkg::FREQ_W'($urandom),
                         mtdg_pkg::NDIV_W'($urandom));
            end
            sent += burst + 1;
         end else begin
            send_word(1'($urandom_range(1)), freq, dv);
            sent++;
         end
      end
      settle();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = mtdg_pkg::CSR_CLOCK_HZ;
      csr_wdata = '0;
      cfg_clock = mtdg_pkg::CLOCK_HZ_RST;
      cfg_tempo = mtdg_pkg::TEMPO_RST;
      tone_half = '0;
      tone_cnt  = '0;
      buzz      = 1'b1;
      tone_run  = 1'b0;
      presc_cnt = '0;
      len_limit = '0;
      len_cnt   = '0;
      note_run  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // heavy receiver stalls
      req_idle_pct = 27;
      rsp_idle_pct = 87;
      test_directed_loads();
      test_config_corners();
      test_random_melody(120, 25'd1000000, 10'd600);

      // heavy sender gaps
      req_idle_pct = 87;
      rsp_idle_pct = 27;
      test_random_melody(120, 25'd20000000, 10'd1);

      // full rate
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_note_completion();
      test_random_melody(120, mtdg_pkg::CLK_W'($urandom_range(1000000, 20000000)),
                         mtdg_pkg::TEMPO_W'($urandom_range(0, 1023)));

      settle();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
